[hw/rtl/i2cbb_pkg.sv]
`timescale 1ns / 1ps

package i2cbb_pkg;

  // request kinds on the input channel
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RECV  = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;

  localparam logic [7:0] AckTimeoutReset = 8'd250;
  localparam logic [2:0] LastBit         = 3'd7;

  typedef struct packed {
    logic       req_type;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  // classification made by the front end
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // bus phases, one-hot
  typedef enum logic [15:0] {
    PH_IDLE  = 16'h0001,
    PH_ST1   = 16'h0002,
    PH_ST2   = 16'h0004,
    PH_SP1   = 16'h0008,
    PH_SP2   = 16'h0010,
    PH_SP3   = 16'h0020,
    PH_AK1   = 16'h0040,
    PH_AK2   = 16'h0080,
    PH_TXA   = 16'h0100,
    PH_TXB   = 16'h0200,
    PH_TXC   = 16'h0400,
    PH_WHI   = 16'h0800,
    PH_WPOLL = 16'h1000,
    PH_RHI   = 16'h2000,
    PH_RSMP  = 16'h4000,
    PH_REND  = 16'h8000
  } phase_e;

endpackage

[hw/rtl/i2cbb_front.sv]
`timescale 1ns / 1ps

module i2cbb_front
  import i2cbb_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_req_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  item_t           item_in;
  logic            push, pop;

  // classify the request
  always_comb begin
    item_in.command   = in_req_i.command;
    item_in.tx_byte   = in_req_i.tx_byte;
    item_in.ack_level = in_req_i.ack_level;
    item_in.sda_in    = in_req_i.sda_in;
    if (in_req_i.req_type == REQ_TICK) begin
      item_in.kind = KIND_TICK;
    end else if (in_req_i.command <= CMD_ACK) begin
      item_in.kind = KIND_CMD;
    end else begin
      item_in.kind = KIND_NOP;
    end
  end

  assign in_ready_o = (cnt_q != FullCnt);
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_pop_i & q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

[hw/rtl/i2cbb_engine.sv]
`timescale 1ns / 1ps

module i2cbb_engine
  import i2cbb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  item_t      q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o
);

  phase_e     phase_q, phase_d;
  logic [2:0] cmd_q, cmd_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] poll_q, poll_d;
  logic       err_q, err_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       dir_q, dir_d;
  logic [7:0] ack_timeout_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_q, res_d;
  logic       done;

  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    err_d   = err_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    dir_d   = dir_q;
    done    = 1'b0;
    if (q_pop_o) begin
      case (q_item_i.kind)
        KIND_CMD: begin
          if (phase_q == PH_IDLE) begin
            cmd_d  = q_item_i.command;
            err_d  = 1'b0;
            bit_d  = '0;
            poll_d = '0;
            unique case (q_item_i.command)
              CMD_START: begin
                dir_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_ST1;
              end
              CMD_STOP: begin
                dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP1;
              end
              CMD_SEND: begin
                dir_d = 1'b1; scl_d = 1'b0; shift_d = q_item_i.tx_byte;
                phase_d = PH_TXA;
              end
              CMD_RECV: begin
                dir_d = 1'b0; sda_d = 1'b1; scl_d = 1'b0; shift_d = '0;
                phase_d = PH_RHI;
              end
              default: begin
                scl_d = 1'b0; dir_d = 1'b1; sda_d = q_item_i.ack_level;
                phase_d = PH_AK1;
              end
            endcase
          end
        end
        KIND_TICK: begin
          unique case (phase_q)
            PH_IDLE: ;
            PH_ST1:  begin sda_d = 1'b0; phase_d = PH_ST2; end
            PH_ST2:  begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
            PH_SP1:  begin scl_d = 1'b1; phase_d = PH_SP2; end
            PH_SP2:  begin sda_d = 1'b1; phase_d = PH_SP3; end
            PH_SP3:  begin phase_d = PH_IDLE; done = 1'b1; end
            PH_AK1:  begin scl_d = 1'b1; phase_d = PH_AK2; end
            PH_AK2:  begin scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1; end
            PH_TXA:  begin sda_d = shift_q[7]; phase_d = PH_TXB; end
            PH_TXB:  begin scl_d = 1'b1; phase_d = PH_TXC; end
            PH_TXC: begin
              scl_d   = 1'b0;
              shift_d = {shift_q[6:0], 1'b0};
              if (bit_q == LastBit) begin
                dir_d = 1'b0; sda_d = 1'b1; phase_d = PH_WHI;
              end else begin
                bit_d = bit_q + 1'b1; phase_d = PH_TXA;
              end
            end
            PH_WHI:  begin scl_d = 1'b1; phase_d = PH_WPOLL; end
            PH_WPOLL: begin
              if (!q_item_i.sda_in) begin
                scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
              end else if (poll_q >= ack_timeout_q) begin
                err_d = 1'b1;
                dir_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP1;
              end else begin
                poll_d = poll_q + 1'b1;
              end
            end
            PH_RHI:  begin scl_d = 1'b1; phase_d = PH_RSMP; end
            PH_RSMP: begin
              shift_d = {shift_q[6:0], q_item_i.sda_in};
              phase_d = PH_REND;
            end
            PH_REND: begin
              if (bit_q == LastBit) begin
                phase_d = PH_IDLE; done = 1'b1;
              end else begin
                bit_d = bit_q + 1'b1; scl_d = 1'b0; phase_d = PH_RHI;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d.scl       = scl_d;
    res_d.sda_drive = dir_d;
    res_d.sda_level = dir_d ? sda_d : 1'b1;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.rx_byte   = (cmd_d == CMD_RECV) ? shift_d : '0;
    res_d.ack_error = err_d;
  end

  assign out_valid_d = q_pop_o | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      cmd_q         <= '0;
      bit_q         <= '0;
      shift_q       <= '0;
      poll_q        <= '0;
      err_q         <= 1'b0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      dir_q         <= 1'b1;
      ack_timeout_q <= AckTimeoutReset;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      poll_q      <= poll_d;
      err_q       <= err_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ack_timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res_d;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> !out_q.busy_res)
    else $error("finished request still reports busy");

  a_err_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (cmd_q == CMD_SEND))
    else $error("ack error outside a send");

endmodule

[hw/rtl/i2c_bitbang_master_unit.sv]
`timescale 1ns / 1ps

// i2c bit engine for a tick-driven master
// in channel: in_valid_i / in_ready_o carry one request (timing tick or command)
//   as an in_req_i struct; out channel: out_valid_o / out_ready_i carry one
//   result per request (line levels, busy, done, rx byte, ack error)
// cfg_we_i writes cfg_wdata_i into the ack timeout register at once; the user must
//   write only while no request is in flight, the block does not enforce it
// a request accepted into the queue waits at the queue head until the result reg
//   is free or being taken, then goes through the phase machine into the result reg
// throughput: one request per cycle while the out channel does not stall, set by
//   the phase machine reading the head of the queue and writing the result register
// reset: queue empty, no result pending, lines idle high with sda driven,
//   ack timeout back to 250
// a stalled out channel holds the result register; the queue then fills and
//   in_ready_o drops once QueueDepth requests wait behind it
module i2c_bitbang_master_unit
  import i2cbb_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_res_o
);

  // queue between classifier and phase machine
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front: classifies each request and buffers it
  i2cbb_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_req_i  (in_req_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  // back: phase machine and result register
  i2cbb_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule
